// ----- rtl/mte_pkg.sv -----
package mte_pkg;

   // Width of every coordinate and element field on the ports
   localparam int FIELD_W = 32;

   // Action codes
   localparam logic [2:0] ACT_SET_CURRENT = 3'd0;
   localparam logic [2:0] ACT_SET_OPERAND = 3'd1;
   localparam logic [2:0] ACT_IDENTITY    = 3'd2;
   localparam logic [2:0] ACT_TRANSLATE   = 3'd3;
   localparam logic [2:0] ACT_MULTIPLY    = 3'd4;
   localparam logic [2:0] ACT_POINT       = 3'd5;
   localparam logic [2:0] ACT_DIRECTION   = 3'd6;

   typedef struct packed {
      logic [2:0]                 action;
      logic [1:0]                 row;
      logic [1:0]                 column;
      logic signed [FIELD_W-1:0]  element_value;
      logic signed [FIELD_W-1:0]  coord_x;
      logic signed [FIELD_W-1:0]  coord_y;
      logic signed [FIELD_W-1:0]  coord_z;
   } mte_req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0]  out_x;
      logic signed [FIELD_W-1:0]  out_y;
      logic signed [FIELD_W-1:0]  out_z;
      logic                       rotation_present;
      logic                       saturated;
   } mte_rsp_type;

   // Bookkeeping that travels with one product through the dot unit
   typedef struct packed {
      logic [1:0] row;      // result row
      logic [1:0] col;      // result column (matrix product only)
      logic       first;    // first term of a dot product: restart the sum
      logic       last;     // last term: saturate and hand the sum back
      logic       done;     // last term of the whole item
      logic       to_word;  // clamp to the matrix word, else to the output field
   } mte_tag_type;

endpackage

// ----- rtl/mte_dot_unit.sv -----
module mte_dot_unit import mte_pkg::*; #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   localparam int OPW       = (WORD_WIDTH > FIELD_W) ? WORD_WIDTH : FIELD_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         iss_valid,
   input  logic                         iss_pass,
   input  logic signed [OPW-1:0]        iss_a,
   input  logic signed [WORD_WIDTH-1:0] iss_b,
   input  mte_tag_type                  iss_tag,
   output logic                         res_valid,
   output mte_tag_type                  res_tag,
   output logic [WORD_WIDTH-1:0]        res_word,
   output logic [FIELD_W-1:0]           res_out,
   output logic                         res_clamp
);

   localparam int NPASS = (WORD_WIDTH > FIELD_W) ? 2 : 1;
   localparam int SLICE = (WORD_WIDTH + NPASS - 1) / NPASS;
   localparam int BPAD  = NPASS * SLICE;
   localparam int PW    = OPW + BPAD;
   localparam int ACC_W = PW + 2;
   localparam int OUT_W = (WORD_WIDTH < FIELD_W) ? WORD_WIDTH : FIELD_W;

   logic [OPW-1:0]         a_abs;
   logic [WORD_WIDTH-1:0]  b_abs;
   logic [BPAD-1:0]        b_mag;
   logic [SLICE-1:0]       b_slice;
   logic [OPW+SLICE-1:0]   partial;
   logic [PW-1:0]          partial_sh;
   logic                   last_pass;
   logic [PW-1:0]          prod_in, prod_ff;
   logic                   neg_ff;
   logic                   pv_in, pv_ff;
   mte_tag_type            tag_ff;
   logic [PW-1:0]          shifted;
   logic signed [ACC_W-1:0] term_mag, term, acc_in, acc_ff;
   logic [ACC_W-WORD_WIDTH:0] hi_w;
   logic [ACC_W-OUT_W:0]   hi_o;
   logic                   fits_w, fits_o;
   logic signed [OUT_W-1:0] sat_o;

   // Magnitudes of both operands; products truncate toward zero on magnitude
   assign a_abs = iss_a[OPW-1] ? OPW'(-iss_a) : OPW'(iss_a);
   assign b_abs = iss_b[WORD_WIDTH-1] ? WORD_WIDTH'(-iss_b) : WORD_WIDTH'(iss_b);
   assign b_mag = BPAD'(b_abs);

   // One slice of the second operand per pass
   assign b_slice    = SLICE'(b_mag >> (SLICE * int'(iss_pass)));
   assign partial    = (OPW+SLICE)'(a_abs) * (OPW+SLICE)'(b_slice);
   assign partial_sh = PW'(partial) << (SLICE * int'(iss_pass));
   assign prod_in    = ((iss_pass == 1'b0) ? PW'(0) : prod_ff) + partial_sh;
   assign last_pass  = (int'(iss_pass) == NPASS - 1);
   assign pv_in      = iss_valid && last_pass;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (iss_valid) begin
         prod_ff <= prod_in;
         neg_ff  <= iss_a[OPW-1] ^ iss_b[WORD_WIDTH-1];
         tag_ff  <= iss_tag;
      end
      if (pv_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Scale, apply the sign and add into the running sum
   assign shifted  = prod_ff >> FRAC_BITS;
   assign term_mag = signed'(ACC_W'(shifted));
   assign term     = neg_ff ? -term_mag : term_mag;
   assign acc_in   = (tag_ff.first ? ACC_W'(0) : acc_ff) + term;

   // Clamp the sum to the matrix word and to the output field
   assign hi_w   = acc_in[ACC_W-1:WORD_WIDTH-1];
   assign hi_o   = acc_in[ACC_W-1:OUT_W-1];
   assign fits_w = (&hi_w) || !(|hi_w);
   assign fits_o = (&hi_o) || !(|hi_o);

   always_comb begin
      if (fits_w) begin
         res_word = acc_in[WORD_WIDTH-1:0];
      end else if (acc_in[ACC_W-1]) begin
         res_word = {1'b1, {(WORD_WIDTH-1){1'b0}}};
      end else begin
         res_word = {1'b0, {(WORD_WIDTH-1){1'b1}}};
      end
      if (fits_o) begin
         sat_o = acc_in[OUT_W-1:0];
      end else if (acc_in[ACC_W-1]) begin
         sat_o = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         sat_o = {1'b0, {(OUT_W-1){1'b1}}};
      end
   end

   assign res_out   = FIELD_W'(sat_o);
   assign res_clamp = tag_ff.to_word ? !fits_w : !fits_o;
   assign res_valid = pv_ff;
   assign res_tag   = tag_ff;

endmodule

// ----- rtl/matrix_transform_engine_unit.sv -----
// Element writes, identity, translation and unused codes strobe the result in the
// cycle after start and take a new item every cycle. Products go through one
// shared multiplier, P passes each (P = 1 up to 32-bit words, else 2); busy
// stays high until the result strobes, and the next item is taken that cycle.
// Reset (synchronous) loads identity into the current matrix; the operand matrix keeps no reset.
module matrix_transform_engine_unit import mte_pkg::*; #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  mte_req_type req_data,
   output logic        rsp_strobe,
   output mte_rsp_type rsp_data
);

   localparam int OPW   = (WORD_WIDTH > FIELD_W) ? WORD_WIDTH : FIELD_W;
   localparam int NPASS = (WORD_WIDTH > FIELD_W) ? 2 : 1;

   localparam logic ONE_CLAMP = (FRAC_BITS >= WORD_WIDTH - 1);
   localparam logic signed [WORD_WIDTH-1:0] ONE_WORD =
      ONE_CLAMP ? {1'b0, {(WORD_WIDTH-1){1'b1}}} : (WORD_WIDTH'(1) << FRAC_BITS);
   localparam logic signed [OPW-1:0] ONE_OP = OPW'(1) << FRAC_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic signed [WORD_WIDTH-1:0] cur_ff [16];
   logic signed [WORD_WIDTH-1:0] cur_in [16];
   logic signed [WORD_WIDTH-1:0] opr_ff [16];
   logic signed [WORD_WIDTH-1:0] row_ff [4];
   logic signed [WORD_WIDTH-1:0] row_in [4];
   logic signed [FIELD_W-1:0]    res_ff [3];
   logic signed [FIELD_W-1:0]    res_in [3];

   logic [1:0]  state_ff, state_in;
   logic [2:0]  act_ff, act_in;
   logic signed [FIELD_W-1:0] vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic [1:0]  ci_ff, ci_in, cj_ff, cj_in, ck_ff, ck_in;
   logic        pass_ff, pass_in;
   logic        satf_ff, satf_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        opr_we;
   logic [3:0]  opr_idx;
   logic signed [WORD_WIDTH-1:0] opr_wdata;

   logic [WORD_WIDTH:0]  elem_sat, tx_sat, ty_sat, tz_sat;
   logic [3:0]   elem_idx;
   logic         is_mul, last_pass;
   logic [1:0]   k_last, j_last, i_last;
   logic signed [WORD_WIDTH-1:0] cur_rd, opr_rd;
   logic signed [FIELD_W-1:0]    v_sel;
   logic                         iss_valid;
   logic signed [OPW-1:0]        iss_a;
   logic signed [WORD_WIDTH-1:0] iss_b;
   mte_tag_type                  iss_tag;
   logic                         res_valid, res_clamp;
   mte_tag_type                  res_tag;
   logic [WORD_WIDTH-1:0]        res_word;
   logic [FIELD_W-1:0]           res_out;
   logic                         rot;

   // Clamp a port value to the matrix word; returns {clamped, value}
   function automatic logic [WORD_WIDTH:0] clamp_word(input logic signed [FIELD_W-1:0] x);
      logic signed [OPW-1:0]   ext;
      logic [OPW-WORD_WIDTH:0] hi;
      ext = OPW'(x);
      hi  = ext[OPW-1:WORD_WIDTH-1];
      if ((&hi) || !(|hi)) begin
         return {1'b0, ext[WORD_WIDTH-1:0]};
      end else if (ext[OPW-1]) begin
         return {1'b1, 1'b1, {(WORD_WIDTH-1){1'b0}}};
      end else begin
         return {1'b1, 1'b0, {(WORD_WIDTH-1){1'b1}}};
      end
   endfunction

   assign elem_sat = clamp_word(req_data.element_value);
   assign tx_sat   = clamp_word(req_data.coord_x);
   assign ty_sat   = clamp_word(req_data.coord_y);
   assign tz_sat   = clamp_word(req_data.coord_z);
   assign elem_idx = {req_data.row, req_data.column};

   // Loop bounds for the running action
   assign is_mul    = (act_ff == ACT_MULTIPLY);
   assign k_last    = (is_mul || act_ff == ACT_POINT) ? 2'd3 : 2'd2;
   assign j_last    = is_mul ? 2'd3 : 2'd0;
   assign i_last    = is_mul ? 2'd3 : 2'd2;
   assign last_pass = (int'(pass_ff) == NPASS - 1);

   // Operand fetch: one current read, one operand read
   assign cur_rd = cur_ff[{ci_ff, ck_ff}];
   assign opr_rd = opr_ff[{ck_ff, cj_ff}];

   always_comb begin
      unique case (ck_ff)
         2'd0:    v_sel = vx_ff;
         2'd1:    v_sel = vy_ff;
         default: v_sel = vz_ff;
      endcase
   end

   always_comb begin
      iss_valid = (state_ff == ST_RUN);
      if (is_mul) begin
         iss_a = OPW'(cur_rd);
         iss_b = opr_rd;
      end else begin
         // translation column enters as a product with one
         iss_a = (ck_ff == 2'd3) ? ONE_OP : OPW'(v_sel);
         iss_b = cur_rd;
      end
      iss_tag.row     = ci_ff;
      iss_tag.col     = cj_ff;
      iss_tag.first   = (ck_ff == 2'd0);
      iss_tag.last    = (ck_ff == k_last);
      iss_tag.done    = (ck_ff == k_last) && (cj_ff == j_last) && (ci_ff == i_last);
      iss_tag.to_word = is_mul;
   end

   mte_dot_unit #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dot (
      .clock     (clock),
      .reset     (reset),
      .iss_valid (iss_valid),
      .iss_pass  (pass_ff),
      .iss_a     (iss_a),
      .iss_b     (iss_b),
      .iss_tag   (iss_tag),
      .res_valid (res_valid),
      .res_tag   (res_tag),
      .res_word  (res_word),
      .res_out   (res_out),
      .res_clamp (res_clamp)
   );

   // Sequencer and state updates
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      vz_in        = vz_ff;
      ci_in        = ci_ff;
      cj_in        = cj_ff;
      ck_in        = ck_ff;
      pass_in      = pass_ff;
      satf_in      = satf_ff;
      rsp_valid_in = 1'b0;
      opr_we       = 1'b0;
      opr_idx      = elem_idx;
      opr_wdata    = elem_sat[WORD_WIDTH-1:0];
      for (int e = 0; e < 16; e++) begin
         cur_in[e] = cur_ff[e];
      end
      for (int e = 0; e < 4; e++) begin
         row_in[e] = row_ff[e];
      end
      for (int e = 0; e < 3; e++) begin
         res_in[e] = res_ff[e];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               act_in  = req_data.action;
               vx_in   = req_data.coord_x;
               vy_in   = req_data.coord_y;
               vz_in   = req_data.coord_z;
               ci_in   = 2'd0;
               cj_in   = 2'd0;
               ck_in   = 2'd0;
               pass_in = 1'b0;
               satf_in = 1'b0;
               for (int e = 0; e < 3; e++) begin
                  res_in[e] = '0;
               end
               unique case (req_data.action)
                  ACT_SET_CURRENT: begin
                     cur_in[elem_idx] = elem_sat[WORD_WIDTH-1:0];
                     satf_in          = elem_sat[WORD_WIDTH];
                     rsp_valid_in     = 1'b1;
                  end
                  ACT_SET_OPERAND: begin
                     opr_we       = 1'b1;
                     satf_in      = elem_sat[WORD_WIDTH];
                     rsp_valid_in = 1'b1;
                  end
                  ACT_IDENTITY: begin
                     for (int e = 0; e < 16; e++) begin
                        cur_in[e] = (e / 4 == e % 4) ? ONE_WORD : '0;
                     end
                     satf_in      = ONE_CLAMP;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_TRANSLATE: begin
                     for (int e = 0; e < 16; e++) begin
                        cur_in[e] = (e / 4 == e % 4) ? ONE_WORD : '0;
                     end
                     cur_in[3]    = tx_sat[WORD_WIDTH-1:0];
                     cur_in[7]    = ty_sat[WORD_WIDTH-1:0];
                     cur_in[11]   = tz_sat[WORD_WIDTH-1:0];
                     satf_in      = ONE_CLAMP | tx_sat[WORD_WIDTH] | ty_sat[WORD_WIDTH]
                                    | tz_sat[WORD_WIDTH];
                     rsp_valid_in = 1'b1;
                  end
                  ACT_MULTIPLY, ACT_POINT, ACT_DIRECTION: begin
                     state_in = ST_RUN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_RUN: begin
            // advance term, column, row once the product is fully issued
            if (last_pass) begin
               pass_in = 1'b0;
               if (ck_ff != k_last) begin
                  ck_in = ck_ff + 2'd1;
               end else begin
                  ck_in = 2'd0;
                  if (cj_ff != j_last) begin
                     cj_in = cj_ff + 2'd1;
                  end else begin
                     cj_in = 2'd0;
                     if (ci_ff != i_last) begin
                        ci_in = ci_ff + 2'd1;
                     end else begin
                        state_in = ST_DRAIN;
                     end
                  end
               end
            end else begin
               pass_in = pass_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DRAIN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Commit finished dot products
      if (res_valid && res_tag.last) begin
         satf_in = satf_ff | res_clamp;
         if (res_tag.to_word) begin
            row_in[res_tag.col] = res_word;
            if (res_tag.col == 2'd3) begin
               cur_in[{res_tag.row, 2'd0}] = row_ff[0];
               cur_in[{res_tag.row, 2'd1}] = row_ff[1];
               cur_in[{res_tag.row, 2'd2}] = row_ff[2];
               cur_in[{res_tag.row, 2'd3}] = res_word;
            end
         end else begin
            res_in[res_tag.row] = res_out;
         end
         if (res_tag.done) begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int e = 0; e < 16; e++) begin
            cur_ff[e] <= (e / 4 == e % 4) ? ONE_WORD : '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int e = 0; e < 16; e++) begin
            cur_ff[e] <= cur_in[e];
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      vz_ff   <= vz_in;
      ci_ff   <= ci_in;
      cj_ff   <= cj_in;
      ck_ff   <= ck_in;
      pass_ff <= pass_in;
      satf_ff <= satf_in;
      for (int e = 0; e < 4; e++) begin
         row_ff[e] <= row_in[e];
      end
      for (int e = 0; e < 3; e++) begin
         res_ff[e] <= res_in[e];
      end
   end

   // Operand matrix: written one element at a time
   always_ff @(posedge clock) begin
      if (opr_we) begin
         opr_ff[opr_idx] <= opr_wdata;
      end
   end

   // Rotation test over the first three columns
   always_comb begin
      rot = 1'b0;
      for (int e = 0; e < 16; e++) begin
         if ((e % 4 != 3) && (cur_ff[e] != '0)) begin
            rot = 1'b1;
         end
      end
   end

   assign busy                      = (state_ff != ST_IDLE);
   assign rsp_strobe                = rsp_valid_ff;
   assign rsp_data.out_x            = res_ff[0];
   assign rsp_data.out_y            = res_ff[1];
   assign rsp_data.out_z            = res_ff[2];
   assign rsp_data.rotation_present = rot;
   assign rsp_data.saturated        = satf_ff;

endmodule

// ----- dv/tb_matrix_transform_engine_unit.sv -----
module tb_matrix_transform_engine_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import mte_pkg::*;

   localparam int          N_ITEMS     = 1450;
   localparam int          FRAC_W      = 16;
   localparam int          CYCLE_LIMIT = 800_000;
   localparam int          DRAIN       = 80;
   localparam logic [2:0]  ACT_UNUSED  = 3'd7;

   localparam logic signed [31:0] ONE  = 32'sh0001_0000;
   localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
   localparam logic signed [31:0] MINV = 32'sh8000_0000;
   localparam logic signed [95:0] WORD_MAX = 96'sd2147483647;
   localparam logic signed [95:0] WORD_MIN = -(96'sd2147483648);

   typedef struct {
      mte_req_type item;
      int unsigned gap;
   } queued_item_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   mte_req_type req_data = '0;
   logic        rsp_strobe;
   mte_rsp_type rsp_data;

   queued_item_type pending_items[$];
   mte_rsp_type     predicted_results[$];

   // predictor copy of the two matrices
   logic signed [31:0] cur_m[16];
   logic signed [31:0] opd_m[16];

   int unsigned total_items = 0;
   int unsigned accepted = 0;
   int unsigned action_count[8];
   int unsigned results_checked = 0;
   int unsigned clamped_results = 0;
   int unsigned no_rotation_results = 0;
   int unsigned mismatches = 0;
   int unsigned burst_left = 0;
   int unsigned idle_left = 0;
   int unsigned cycle_count = 0;

   matrix_transform_engine_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // (a * b) >> FRAC_W, rounded toward zero
   function automatic logic signed [95:0] fixed_product(input logic signed [31:0] a,
                                                         input logic signed [31:0] b);
      logic signed [95:0] wa, wb, p;
      wa = a;
      wb = b;
      p = wa * wb;
      if (p < 0)
         return -((-p) >>> FRAC_W);
      return p >>> FRAC_W;
   endfunction

   // clamp to a signed 32-bit word; bit 32 flags a clamp
   function automatic logic [32:0] clamp_word(input logic signed [95:0] v);
      if (v > WORD_MAX)
         return {1'b1, MAXV};
      if (v < WORD_MIN)
         return {1'b1, MINV};
      return {1'b0, v[31:0]};
   endfunction

   function automatic void load_identity();
      for (int i = 0; i < 16; i++)
         cur_m[i] = (i % 5 == 0) ? ONE : '0;
   endfunction

   // update the matrices for one item and work out its result
   function automatic mte_rsp_type apply_action(input mte_req_type it);
      mte_rsp_type        rs;
      logic signed [95:0] acc;
      logic signed [31:0] vec[3];
      logic signed [31:0] prod[16];
      logic [32:0]        cl;
      logic signed [31:0] outv[3];
      logic [3:0]         idx;
      bit                 clamped;
      bit                 rot;

      rs = '0;
      clamped = 1'b0;
      rot = 1'b0;
      vec[0] = it.coord_x;
      vec[1] = it.coord_y;
      vec[2] = it.coord_z;
      outv[0] = '0;
      outv[1] = '0;
      outv[2] = '0;
      idx = {it.row, it.column};

      case (it.action)
         ACT_SET_CURRENT: cur_m[idx] = it.element_value;
         ACT_SET_OPERAND: opd_m[idx] = it.element_value;
         ACT_IDENTITY:    load_identity();
         ACT_TRANSLATE: begin
            load_identity();
            for (int i = 0; i < 3; i++)
               cur_m[i * 4 + 3] = vec[i];
         end
         ACT_MULTIPLY: begin
            for (int i = 0; i < 4; i++)
               for (int j = 0; j < 4; j++) begin
                  acc = '0;
                  for (int k = 0; k < 4; k++)
                     acc = acc + fixed_product(cur_m[i * 4 + k], opd_m[k * 4 + j]);
                  cl = clamp_word(acc);
                  prod[i * 4 + j] = cl[31:0];
                  clamped |= cl[32];
               end
            for (int i = 0; i < 16; i++)
               cur_m[i] = prod[i];
         end
         ACT_POINT, ACT_DIRECTION: begin
            for (int i = 0; i < 3; i++) begin
               if (it.action == ACT_POINT)
                  acc = cur_m[i * 4 + 3];
               else
                  acc = '0;
               for (int k = 0; k < 3; k++)
                  acc = acc + fixed_product(vec[k], cur_m[i * 4 + k]);
               cl = clamp_word(acc);
               outv[i] = cl[31:0];
               clamped |= cl[32];
            end
         end
         default: ;
      endcase

      // rotation test over columns 0..2 of every row
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 3; j++)
            if (cur_m[i * 4 + j] != 0)
               rot = 1'b1;

      rs.out_x = outv[0];
      rs.out_y = outv[1];
      rs.out_z = outv[2];
      rs.rotation_present = rot;
      rs.saturated = clamped;
      return rs;
   endfunction

   // mostly short gaps, a few long ones, and stretches with none
   function automatic int unsigned next_gap();
      int unsigned sel;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 45)
         return 0;
      if (sel < 85)
         return $urandom_range(1, 3);
      if (sel < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Q16.16 value: mostly modest magnitudes, some full range and extremes
   function automatic logic signed [31:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(0, 15);
      if (sel < 4)
         return $urandom;
      if (sel < 11)
         return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      if (sel < 13)
         return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      if (sel == 13)
         return ONE;
      if (sel == 14)
         return -ONE;
      case ($urandom_range(0, 2))
         0:       return MAXV;
         1:       return MINV;
         default: return '0;
      endcase
   endfunction

   task automatic queue_item(input logic [2:0] act, input logic [1:0] r, input logic [1:0] c,
                             input logic signed [31:0] e, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic signed [31:0] z);
      queued_item_type q;
      q.item.action = act;
      q.item.row = r;
      q.item.column = c;
      q.item.element_value = e;
      q.item.coord_x = x;
      q.item.coord_y = y;
      q.item.coord_z = z;
      q.gap = next_gap();
      pending_items.push_back(q);
      total_items++;
   endtask

   task automatic queue_transform();
      queue_item($urandom_range(0, 1) ? ACT_POINT : ACT_DIRECTION,
                 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom,
                 pick_value(), pick_value(), pick_value());
   endtask

   task automatic queue_element(input logic [2:0] act);
      queue_item(act, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_value(),
                 $urandom, $urandom, $urandom);
   endtask

   // stimulus, reset and end of run
   initial begin
      // directed: extremes on the identity matrix, then on a saturated diagonal
      queue_item(ACT_POINT, 0, 0, 0, 32'sh0001_8000, -32'sh0002_0000, MAXV);
      queue_item(ACT_SET_CURRENT, 0, 0, MAXV, 0, 0, 0);
      queue_item(ACT_SET_CURRENT, 3, 3, MINV, MAXV, MINV, MAXV);
      queue_item(ACT_POINT, 3, 3, MINV, MAXV, MINV, MAXV);
      queue_item(ACT_DIRECTION, 1, 2, MAXV, MINV, MAXV, ONE);
      queue_item(ACT_IDENTITY, 3, 3, MINV, MAXV, MINV, MAXV);
      queue_item(ACT_TRANSLATE, 0, 0, 0, MAXV, MINV, 32'sh0001_8000);
      queue_item(ACT_POINT, 2, 1, 0, ONE, MINV, -ONE);
      queue_item(ACT_DIRECTION, 0, 3, 0, MAXV, MAXV, MAXV);
      queue_item(ACT_UNUSED, 2, 1, MAXV, MAXV, MINV, ONE);
      // clear the diagonal so no rotation is left, only the translation
      queue_item(ACT_SET_CURRENT, 0, 0, 0, 0, 0, 0);
      queue_item(ACT_SET_CURRENT, 1, 1, 0, 0, 0, 0);
      queue_item(ACT_SET_CURRENT, 2, 2, 0, 0, 0, 0);
      queue_item(ACT_POINT, 1, 0, 0, ONE, ONE, ONE);
      // fill every operand entry before any multiply
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) begin
            if (r == 0 && c == 3)
               queue_item(ACT_SET_OPERAND, 2'(r), 2'(c), MAXV, 0, 0, 0);
            else if (r == 3 && c == 0)
               queue_item(ACT_SET_OPERAND, 2'(r), 2'(c), MINV, 0, 0, 0);
            else if (r == c)
               queue_item(ACT_SET_OPERAND, 2'(r), 2'(c), 2 * ONE, 0, 0, 0);
            else
               queue_item(ACT_SET_OPERAND, 2'(r), 2'(c),
                          $urandom_range(0, 32'h0004_0000) - 32'h0002_0000, 0, 0, 0);
         end
      queue_item(ACT_MULTIPLY, 0, 0, 0, 0, 0, 0);
      queue_item(ACT_IDENTITY, 0, 0, 0, 0, 0, 0);
      queue_item(ACT_MULTIPLY, 3, 3, MAXV, MINV, MAXV, MINV);
      queue_item(ACT_POINT, 0, 0, 0, ONE, -ONE, 32'sh0000_8000);

      // random: mostly setup-then-transform sequences, some noise
      while (total_items < N_ITEMS) begin
         int unsigned sel;
         sel = $urandom_range(0, 99);
         if (sel < 30) begin
            if ($urandom_range(0, 1))
               queue_item(ACT_IDENTITY, 2'($urandom), 2'($urandom), $urandom, $urandom,
                          $urandom, $urandom);
            else
               queue_item(ACT_TRANSLATE, 2'($urandom), 2'($urandom), $urandom, pick_value(),
                          pick_value(), pick_value());
            repeat ($urandom_range(0, 4)) queue_element(ACT_SET_CURRENT);
            repeat ($urandom_range(2, 8)) queue_transform();
         end else if (sel < 50) begin
            repeat ($urandom_range(1, 6)) queue_element(ACT_SET_OPERAND);
            queue_item(ACT_MULTIPLY, 2'($urandom), 2'($urandom), $urandom, $urandom,
                       $urandom, $urandom);
            repeat ($urandom_range(1, 4)) queue_transform();
         end else if (sel < 80) begin
            repeat ($urandom_range(3, 10)) queue_transform();
         end else if (sel < 92) begin
            queue_item(3'($urandom_range(0, 7)), 2'($urandom), 2'($urandom), $urandom,
                       $urandom, $urandom, $urandom);
         end else begin
            burst_left = $urandom_range(20, 60);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (accepted < total_items || predicted_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("Run covered %0d items: %0d points, %0d directions, %0d multiplies,",
               accepted, action_count[ACT_POINT], action_count[ACT_DIRECTION],
               action_count[ACT_MULTIPLY]);
      $display("%0d unused codes; %0d results checked, %0d clamped, %0d without rotation",
               action_count[ACT_UNUSED], results_checked, clamped_results,
               no_rotation_results);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // driver: hold an item until it is taken, then wait out the next gap
   always @(posedge clock) begin
      queued_item_type next_q;
      if (reset) begin
         start <= 1'b0;
         for (int i = 0; i < 16; i++)
            opd_m[i] = '0;
         load_identity();
      end else if (start && !busy) begin
         predicted_results.push_back(apply_action(req_data));
         action_count[req_data.action]++;
         accepted++;
         if (pending_items.size() != 0 && pending_items[0].gap == 0) begin
            next_q = pending_items.pop_front();
            req_data <= next_q.item;
         end else begin
            start <= 1'b0;
            if (pending_items.size() != 0)
               idle_left <= pending_items[0].gap - 1;
         end
      end else if (!start && pending_items.size() != 0) begin
         if (idle_left > 0) begin
            idle_left <= idle_left - 1;
         end else begin
            next_q = pending_items.pop_front();
            req_data <= next_q.item;
            start <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                  $time, name, want, want, got, got);
         mismatches++;
      end
   endtask

   // monitor: compare each strobed result with the oldest prediction
   always @(posedge clock) begin
      mte_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (predicted_results.size() == 0) begin
            $display("%0t: result with nothing expected, got x=%0d y=%0d z=%0d rot=%0b sat=%0b",
                     $time, rsp_data.out_x, rsp_data.out_y, rsp_data.out_z,
                     rsp_data.rotation_present, rsp_data.saturated);
            mismatches++;
         end else begin
            want = predicted_results.pop_front();
            check_field("out_x", want.out_x, rsp_data.out_x);
            check_field("out_y", want.out_y, rsp_data.out_y);
            check_field("out_z", want.out_z, rsp_data.out_z);
            check_field("rotation_present", 32'(want.rotation_present),
                        32'(rsp_data.rotation_present));
            check_field("saturated", 32'(want.saturated), 32'(rsp_data.saturated));
            results_checked++;
            if (want.saturated)
               clamped_results++;
            if (!want.rotation_present)
               no_rotation_results++;
         end
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d of %0d items taken, %0d results waiting",
                  $time, cycle_count, accepted, total_items, predicted_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule

// ----- matrix_transform_engine_unit.f -----
rtl/mte_pkg.sv
rtl/mte_dot_unit.sv
rtl/matrix_transform_engine_unit.sv
dv/tb_matrix_transform_engine_unit.sv
